// File: rtl/smpfp_pkg.sv
// shared types and constants for the sign-magnitude pose frame parser
// no dependencies
`timescale 1ns / 1ps

package smpfp_pkg;

   localparam int unsigned FRAME_LEN = 14;
   localparam int unsigned STORE_LEN = FRAME_LEN - 1;
   localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);
   localparam int unsigned YAW_CFG_W = 15;

   localparam logic [7:0]           FRAME_HEAD = 8'hFA;
   localparam logic [7:0]           FRAME_TAIL = 8'hAB;
   localparam logic [YAW_CFG_W-1:0] YAW_RESET  = 15'd1800;

   typedef enum logic [1:0] {
      ST_INCOMPLETE = 2'd0,
      ST_ACCEPT     = 2'd1,
      ST_BAD_FRAME  = 2'd2,
      ST_BAD_YAW    = 2'd3
   } status_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      status_type         status;
      logic signed [24:0] x_cm;
      logic signed [24:0] y_cm;
      logic signed [15:0] yaw_tenths;
   } decode_type;

endpackage

// File: rtl/smpfp_decode.sv
// frame check and sign-magnitude decode of one complete frame
// depends on smpfp_pkg
`timescale 1ns / 1ps

module smpfp_decode (
   input  smpfp_pkg::frame_type                      frame,
   input  logic [smpfp_pkg::YAW_CFG_W-1:0]          max_yaw,
   output smpfp_pkg::decode_type                     result
);
   import smpfp_pkg::*;

   logic        format_bad;
   logic [23:0] x_mag;
   logic [23:0] y_mag;
   logic [23:0] yaw_mag;
   logic [15:0] yaw_pos;

   assign format_bad = (frame[0] != FRAME_HEAD) || (frame[13] != FRAME_TAIL) ||
                       (frame[1][7:1] != 7'd0) || (frame[5][7:1] != 7'd0) ||
                       (frame[9][7:1] != 7'd0);

   assign x_mag   = {frame[2], frame[3], frame[4]};
   assign y_mag   = {frame[6], frame[7], frame[8]};
   assign yaw_mag = {frame[10], frame[11], frame[12]};
   assign yaw_pos = {1'b0, yaw_mag[14:0]};

   always_comb begin
      if (format_bad) begin
         result.status = ST_BAD_FRAME;
      end else if (yaw_mag > {9'd0, max_yaw}) begin
         result.status = ST_BAD_YAW;
      end else begin
         result.status = ST_ACCEPT;
      end
      result.x_cm       = frame[1][0] ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
      result.y_cm       = frame[5][0] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
      result.yaw_tenths = frame[9][0] ? -$signed(yaw_pos) : $signed(yaw_pos);
   end

endmodule

// File: rtl/sign_magnitude_pose_frame_parser.sv
// top level of the sign-magnitude pose frame parser
// depends on smpfp_pkg and smpfp_decode
//
// usage: each request carries one received byte and its millisecond receive
// time. bytes are gathered into 14-byte frames that open on 0xFA; every
// request yields exactly one response with a status, the decoded pose of an
// accepted frame, its relay time and the running good and bad frame counts.
// requests enter an input register; when the output side can advance, the
// frame store, the check of a completed frame and the counters update and
// the response is loaded into the output register. one request is taken
// every cycle while the response side keeps up.
// if the receiver stalls, the output register holds its
// response and the input register still takes one more request before
// req_tready drops. the csr channel writes the largest accepted yaw
// magnitude; it is always ready and should be written only while idle.
// reset empties the frame, clears counters and relay epoch and loads the
// yaw limit with 1800.
`timescale 1ns / 1ps

module sign_magnitude_pose_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [39:0]                          req_tdata,   // rx_byte, now_ms
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [167:0]                         rsp_tdata,   // x_cm, y_cm, yaw_tenths,
                                                             // relay_time_ms, good_frames,
                                                             // bad_frames, zero pad
   output logic [1:0]                           rsp_tuser,   // status
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [smpfp_pkg::YAW_CFG_W-1:0]      csr_data
);
   import smpfp_pkg::*;

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic [31:0]          in_time_ff;
   logic                 advance;
   logic                 step;

   logic [YAW_CFG_W-1:0] max_yaw_ff;
   logic [7:0]           store_ff [STORE_LEN];
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic                 epoch_ff;
   logic [31:0]          relay_ff;
   logic [31:0]          relay_in;
   logic [31:0]          last_time_ff;
   logic [31:0]          good_ff;
   logic [31:0]          good_in;
   logic [31:0]          bad_ff;
   logic [31:0]          bad_in;
   logic                 store_we;
   logic [FILL_W-1:0]    store_idx;
   logic                 accept;
   logic                 is_head;

   frame_type            frame;
   decode_type           dec;
   status_type           status_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic signed [24:0]   rsp_x_ff;
   logic signed [24:0]   rsp_y_ff;
   logic signed [15:0]   rsp_yaw_ff;
   logic [31:0]          rsp_relay_ff;
   logic [31:0]          rsp_good_ff;
   logic [31:0]          rsp_bad_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_time_ff <= req_tdata[39:8];
      end
   end

   always_comb begin
      for (int i = 0; i < STORE_LEN; i++) begin
         frame[i] = store_ff[i];
      end
      frame[FRAME_LEN-1] = in_byte_ff;
   end

   smpfp_decode u_decode (
      .frame   (frame),
      .max_yaw (max_yaw_ff),
      .result  (dec)
   );

   assign is_head = (in_byte_ff == FRAME_HEAD);

   always_comb begin
      fill_in   = fill_ff;
      store_we  = 1'b0;
      store_idx = fill_ff;
      status_in = ST_INCOMPLETE;
      accept    = 1'b0;
      good_in   = good_ff;
      bad_in    = bad_ff;
      relay_in  = epoch_ff ? relay_ff + (in_time_ff - last_time_ff) : '0;
      if (fill_ff == '0) begin
         store_idx = '0;
         store_we  = is_head;
         fill_in   = is_head ? FILL_W'(1) : '0;
      end else if (fill_ff < FILL_W'(STORE_LEN)) begin
         store_we = 1'b1;
         fill_in  = fill_ff + FILL_W'(1);
      end else begin
         status_in = dec.status;
         if (dec.status == ST_ACCEPT) begin
            accept  = 1'b1;
            good_in = good_ff + 32'd1;
            fill_in = '0;
         end else begin
            // a head byte at the end of a rejected frame opens the next one
            bad_in    = bad_ff + 32'd1;
            store_idx = '0;
            store_we  = is_head;
            fill_in   = is_head ? FILL_W'(1) : '0;
         end
      end
   end

   // frame state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         epoch_ff     <= 1'b0;
         relay_ff     <= '0;
         last_time_ff <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
      end else if (step) begin
         fill_ff <= fill_in;
         good_ff <= good_in;
         bad_ff  <= bad_in;
         if (accept) begin
            epoch_ff     <= 1'b1;
            relay_ff     <= relay_in;
            last_time_ff <= in_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[store_idx] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_yaw_ff <= YAW_RESET;
      end else if (csr_valid && csr_ready) begin
         max_yaw_ff <= csr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_status_ff <= status_in;
         rsp_x_ff      <= accept ? dec.x_cm : '0;
         rsp_y_ff      <= accept ? dec.y_cm : '0;
         rsp_yaw_ff    <= accept ? dec.yaw_tenths : '0;
         rsp_relay_ff  <= accept ? relay_in : '0;
         rsp_good_ff   <= good_in;
         rsp_bad_ff    <= bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_bad_ff, rsp_good_ff, rsp_relay_ff,
                        rsp_yaw_ff, rsp_y_ff, rsp_x_ff};

endmodule

// File: test/tb_sign_magnitude_pose_frame_parser.sv
// testbench for sign_magnitude_pose_frame_parser: random and directed byte streams
// checked against an internal frame parser model; depends on smpfp_pkg and the rtl
`timescale 1ns / 1ps

module tb_sign_magnitude_pose_frame_parser;
   import smpfp_pkg::*;

   localparam int IDLE_PERCENT    = 28;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
   } serial_byte_type;

   typedef struct packed {
      status_type         status;
      logic signed [24:0] x_cm;
      logic signed [24:0] y_cm;
      logic signed [15:0] yaw_tenths;
      logic [31:0]        relay_ms;
      logic [31:0]        good_frames;
      logic [31:0]        bad_frames;
   } pose_result_type;

   typedef enum int {FLAW_NONE, FLAW_TAIL, FLAW_SIGN, FLAW_YAW, FLAW_RESTART} frame_flaw_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [39:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [167:0]         rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [YAW_CFG_W-1:0] csr_data;

   // parser model state
   logic [7:0]           frame_bytes [FRAME_LEN];
   int unsigned          fill_count;
   bit                   epoch_open;
   logic [31:0]          relay_ms;
   logic [31:0]          last_rx_ms;
   logic [31:0]          good_total;
   logic [31:0]          bad_total;
   logic [YAW_CFG_W-1:0] yaw_limit;

   serial_byte_type      pending_bytes [$];
   pose_result_type      expected_poses [$];
   serial_byte_type      next_byte;
   pose_result_type      want_pose;

   bit                   req_fire;
   bit                   no_idle;
   bit                   long_hold;
   int                   hold_left;
   int                   quiet_cycles;
   int                   mismatches;
   int                   responses_checked;
   int                   frame_bytes_sent;
   logic [31:0]          stamp_ms;
   logic [YAW_CFG_W-1:0] phase_limit;

   sign_magnitude_pose_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sm_value(logic [7:0] sign, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2);
      logic [31:0] mag;
      mag = {8'h00, b0, b1, b2};
      return (sign != 8'h00) ? 32'h0 - mag : mag;
   endfunction

   task parse_byte(input serial_byte_type item, output pose_result_type res);
      logic [23:0] yaw_mag;
      logic [31:0] value;
      status_type  st;
      res = '0;
      st  = ST_INCOMPLETE;
      if (fill_count == 0) begin
         if (item.rx_byte == FRAME_HEAD) begin
            frame_bytes[0] = item.rx_byte;
            fill_count     = 1;
         end
      end else begin
         frame_bytes[fill_count] = item.rx_byte;
         fill_count++;
         if (fill_count == FRAME_LEN) begin
            yaw_mag = {frame_bytes[10], frame_bytes[11], frame_bytes[12]};
            if (frame_bytes[0] != FRAME_HEAD || frame_bytes[13] != FRAME_TAIL ||
                frame_bytes[1] > 8'd1 || frame_bytes[5] > 8'd1 || frame_bytes[9] > 8'd1)
               st = ST_BAD_FRAME;
            else if (yaw_mag > yaw_limit)
               st = ST_BAD_YAW;
            else
               st = ST_ACCEPT;
            fill_count = 0;
            if (st != ST_ACCEPT) begin
               bad_total++;
               // a head byte in the last slot opens the next frame
               if (item.rx_byte == FRAME_HEAD) begin
                  frame_bytes[0] = item.rx_byte;
                  fill_count     = 1;
               end
            end else begin
               value = sm_value(frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4]);
               res.x_cm = value[24:0];
               value = sm_value(frame_bytes[5], frame_bytes[6], frame_bytes[7], frame_bytes[8]);
               res.y_cm = value[24:0];
               value = sm_value(frame_bytes[9], frame_bytes[10], frame_bytes[11], frame_bytes[12]);
               res.yaw_tenths = value[15:0];
               if (!epoch_open) begin
                  epoch_open = 1'b1;
                  relay_ms   = 32'h0;
               end else begin
                  relay_ms = relay_ms + (item.now_ms - last_rx_ms);
               end
               last_rx_ms   = item.now_ms;
               res.relay_ms = relay_ms;
               good_total++;
            end
         end
      end
      res.status      = st;
      res.good_frames = good_total;
      res.bad_frames  = bad_total;
   endtask

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   task compare_field(input string what, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_byte = pending_bytes.pop_front();
            req_tdata  <= {next_byte.now_ms, next_byte.rx_byte};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (long_hold) begin
         hold_left = HOLD_OFF_CYCLES;
         long_hold = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_fire     = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            parse_byte(serial_byte_type'({req_tdata[7:0], req_tdata[39:8]}), want_pose);
            expected_poses.push_back(want_pose);
         end
         if (rsp_tvalid && rsp_tready) begin
            responses_checked++;
            if (expected_poses.size() == 0) begin
               report_mismatch("unexpected response", {30'h0, rsp_tuser}, 32'h0);
            end else begin
               want_pose = expected_poses.pop_front();
               compare_field("status", {30'h0, rsp_tuser}, {30'h0, want_pose.status});
               compare_field("x_cm", {7'h0, rsp_tdata[24:0]}, {7'h0, want_pose.x_cm});
               compare_field("y_cm", {7'h0, rsp_tdata[49:25]}, {7'h0, want_pose.y_cm});
               compare_field("yaw_tenths", {16'h0, rsp_tdata[65:50]},
                             {16'h0, want_pose.yaw_tenths});
               compare_field("relay_time_ms", rsp_tdata[97:66], want_pose.relay_ms);
               compare_field("good_frames", rsp_tdata[129:98], want_pose.good_frames);
               compare_field("bad_frames", rsp_tdata[161:130], want_pose.bad_frames);
            end
         end
         if (req_fire || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", expected_poses.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   task push_byte(input logic [7:0] b);
      // mostly small steps, sometimes a jump anywhere in the wrapping range
      if ($urandom_range(99) < 10)
         stamp_ms = $urandom;
      else
         stamp_ms = stamp_ms + $urandom_range(50);
      pending_bytes.push_back(serial_byte_type'{rx_byte: b, now_ms: stamp_ms});
   endtask

   function automatic logic [23:0] random_mag();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         return 24'h0;
      else if (pick < 20)
         return 24'hFFFFFF;
      return 24'($urandom);
   endfunction

   task queue_frame(input frame_flaw_type flaw, input int keep);
      logic [7:0]  frm [FRAME_LEN];
      logic [23:0] mag;
      logic [7:0]  tail;
      frm[0] = FRAME_HEAD;
      for (int s = 1; s < 10; s += 4) begin
         frm[s] = 8'($urandom_range(1));
         mag = random_mag();
         {frm[s+1], frm[s+2], frm[s+3]} = mag;
      end
      if (flaw == FLAW_YAW)
         mag = 24'(($urandom_range(3) == 0) ? phase_limit + 24'd1
                                            : $urandom_range(24'hFFFFFF, phase_limit + 1));
      else
         mag = 24'(($urandom_range(9) == 0) ? phase_limit : $urandom_range(phase_limit));
      {frm[10], frm[11], frm[12]} = mag;
      frm[13] = FRAME_TAIL;
      case (flaw)
         FLAW_TAIL: begin
            tail = 8'($urandom_range(255));
            frm[13] = (tail == FRAME_TAIL) ? ~FRAME_TAIL : tail;
         end
         FLAW_SIGN: begin
            frm[1 + 4 * $urandom_range(2)] = 8'($urandom_range(255, 2));
         end
         FLAW_RESTART: begin
            frm[13] = FRAME_HEAD;
         end
         default: ;
      endcase
      for (int i = 0; i < keep; i++)
         push_byte(frm[i]);
      frame_bytes_sent += keep;
   endtask

   task queue_random(input int n_items);
      int             start;
      int             pick;
      frame_flaw_type flaw;
      start = frame_bytes_sent;
      while (frame_bytes_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
         end else if (pick < 14) begin
            // broken frame cut short
            queue_frame(FLAW_NONE, $urandom_range(13, 1));
         end
         pick = $urandom_range(99);
         if (pick < 60)
            flaw = FLAW_NONE;
         else if (pick < 70)
            flaw = FLAW_TAIL;
         else if (pick < 80)
            flaw = FLAW_SIGN;
         else if (pick < 90)
            flaw = FLAW_YAW;
         else
            flaw = FLAW_RESTART;
         queue_frame(flaw, FRAME_LEN);
      end
   endtask

   task drain();
      while (pending_bytes.size() != 0 || expected_poses.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_yaw_limit(input logic [YAW_CFG_W-1:0] limit);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      yaw_limit   = limit;
      phase_limit = limit;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task queue_directed();
      logic [7:0] extreme_frame [FRAME_LEN];
      logic [7:0] restart_frame [FRAME_LEN];
      // x at negative full scale, y negative zero, yaw at the negative limit
      extreme_frame = '{8'hFA, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00,
                        8'h00, 8'h01, 8'h00, 8'h07, 8'h08, 8'hAB};
      // bad sign byte, head byte in the tail slot reopens a frame
      restart_frame = '{8'hFA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                        8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFA};
      push_byte(8'h00);
      push_byte(8'hFF);
      foreach (extreme_frame[i]) push_byte(extreme_frame[i]);
      foreach (restart_frame[i]) push_byte(restart_frame[i]);
      frame_bytes_sent += 2 * FRAME_LEN;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      fill_count = 0;
      epoch_open = 1'b0;
      relay_ms   = '0;
      last_rx_ms = '0;
      good_total = '0;
      bad_total  = '0;
      yaw_limit  = YAW_RESET;
      phase_limit = YAW_RESET;
      hold_left  = 0;
      long_hold  = 1'b0;
      no_idle    = 1'b0;
      mismatches = 0;
      responses_checked = 0;
      frame_bytes_sent  = 0;
      stamp_ms   = 32'hFFFF_FFF0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset limit, directed cases then random frames
      queue_directed();
      queue_random(230);
      drain();

      // zero limit with a long receiver stall
      write_yaw_limit('0);
      queue_random(200);
      @(negedge clock);
      long_hold = 1'b1;
      drain();

      // full limit with no idling on either side
      write_yaw_limit({YAW_CFG_W{1'b1}});
      no_idle = 1'b1;
      queue_random(200);
      drain();
      no_idle = 1'b0;

      write_yaw_limit(YAW_CFG_W'($urandom_range(32767)));
      queue_random(200);
      @(negedge clock);
      long_hold = 1'b1;
      drain();

      write_yaw_limit(YAW_RESET);
      queue_random(250);
      drain();

      $display("checked %0d responses over %0d frame bytes and five yaw limit settings",
               responses_checked, frame_bytes_sent);
      $display("frames accepted %0d, rejected %0d, mismatches %0d",
               good_total, bad_total, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sign_magnitude_pose_frame_parser.f
rtl/smpfp_pkg.sv
rtl/smpfp_decode.sv
rtl/sign_magnitude_pose_frame_parser.sv
test/tb_sign_magnitude_pose_frame_parser.sv
